@@ sv/bkm_pkg.sv @@
// Package for the byte add/XOR key mixer.
// Holds the round schedule and the byte types; no dependencies.
package bkm_pkg;

  localparam int unsigned NumRounds  = 8;
  localparam int unsigned HalfBytes  = 4;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned HalfWidth  = 32;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned InTdataW   = KeyWidth + WordWidth;  // 96, already whole bytes

  typedef logic [7:0] byte_t;
  typedef logic [1:0] sel_t;

  // Per round: key bytes i and j, sources a b c d, destinations of m and n
  typedef struct packed {
    sel_t ki;
    sel_t kj;
    sel_t a;
    sel_t b;
    sel_t c;
    sel_t d;
    sel_t dst_m;
    sel_t dst_n;
  } round_t;

  localparam round_t RoundTab [NumRounds] = '{
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3},
    '{2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd0, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd1}
  };

endpackage

@@ sv/bkm_mix_half.sv @@
// Eight-round byte add/XOR mix of one 4-byte half with the 4-byte key.
// Purely combinational; uses bkm_pkg for the round schedule.
module bkm_mix_half (
  input  logic [bkm_pkg::KeyWidth-1:0]  key_i,
  input  logic [bkm_pkg::HalfWidth-1:0] half_i,
  output logic [bkm_pkg::HalfWidth-1:0] half_o
);

  bkm_pkg::byte_t k [bkm_pkg::HalfBytes];
  bkm_pkg::byte_t y [bkm_pkg::HalfBytes];
  bkm_pkg::byte_t ki, kj, m, n;

  always_comb begin
    for (int i = 0; i < bkm_pkg::HalfBytes; i++) begin
      k[i] = key_i[8*i +: 8];
      y[i] = half_i[8*i +: 8];
    end
    ki = '0;
    kj = '0;
    m  = '0;
    n  = '0;
    // rounds chain through y; all reads of a round happen before its writes
    for (int r = 0; r < bkm_pkg::NumRounds; r++) begin
      ki = k[bkm_pkg::RoundTab[r].ki];
      kj = k[bkm_pkg::RoundTab[r].kj];
      m  = (y[bkm_pkg::RoundTab[r].a] + (ki ^ kj)) ^ y[bkm_pkg::RoundTab[r].b];
      n  = ((ki + kj) + y[bkm_pkg::RoundTab[r].c]) ^ y[bkm_pkg::RoundTab[r].d];
      y[bkm_pkg::RoundTab[r].dst_m] = m;
      y[bkm_pkg::RoundTab[r].dst_n] = n;
    end
    for (int i = 0; i < bkm_pkg::HalfBytes; i++) begin
      half_o[8*i +: 8] = y[i];
    end
  end

endmodule

@@ sv/byte_add_xor_key_mix.sv @@
// Byte add/XOR key mixer: one result beat per input beat. Each input beat is captured in
// an input register, the eight mixing rounds of both halves run in one combinational pass,
// and the result is held in an output register. One beat is accepted every cycle while the
// output side keeps taking results; an accepted beat moves from the input register into
// the output register as soon as that register is free, and is taken from there.
// Throughput is set by the input/result register pair, which advance together, and
// the input side stalls only when both registers hold beats and the output side is stalled.
// Uses bkm_pkg and bkm_mix_half (two instances, one per half).
module byte_add_xor_key_mix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // fields from bit 0 up: mix_key[31:0], data_word[63:0]
  input  logic [bkm_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fields from bit 0 up: mixed_word[63:0]
  output logic [bkm_pkg::WordWidth-1:0]   m_axis_tdata
);

  logic                             in_valid_q;
  logic [bkm_pkg::KeyWidth-1:0]     key_q;
  logic [bkm_pkg::WordWidth-1:0]    word_q;
  logic                             out_valid_q;
  logic [bkm_pkg::WordWidth-1:0]    res_q;
  logic [bkm_pkg::WordWidth-1:0]    res_d;
  logic                             out_free;
  logic                             advance;
  logic                             accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= s_axis_tdata[bkm_pkg::KeyWidth-1:0];
      word_q <= s_axis_tdata[bkm_pkg::InTdataW-1:bkm_pkg::KeyWidth];
    end
  end

  bkm_mix_half u_mix_lo (
    .key_i  (key_q),
    .half_i (word_q[bkm_pkg::HalfWidth-1:0]),
    .half_o (res_d[bkm_pkg::HalfWidth-1:0])
  );

  bkm_mix_half u_mix_hi (
    .key_i  (key_q),
    .half_i (word_q[bkm_pkg::WordWidth-1:bkm_pkg::HalfWidth]),
    .half_o (res_d[bkm_pkg::WordWidth-1:bkm_pkg::HalfWidth])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // an accepted beat sits in the input register next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_valid_q)
    else $error("accepted beat not captured");

  // a beat that moves on shows up as a result next cycle
  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("advanced beat missing at output");

  // both registers full and output stalled: input must hold off
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full");

  // result register carries the mix of the beat that advanced
  a_result_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tdata == $past(res_d)))
    else $error("result register does not match mixed word");

endmodule

@@ tb/byte_add_xor_key_mix_tb.sv @@
// Self-checking bench for byte_add_xor_key_mix: a queued stream driver with random gaps and
// a result monitor with random back-pressure, checked against a built-in byte mixing predictor.
// Depends on bkm_pkg and the byte_add_xor_key_mix RTL.
module byte_add_xor_key_mix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandBeats = 950;
  localparam int unsigned WaitMax   = 14;

  // Mixing schedule per round: key bytes i and j, reads a b c d, write slots of m and n
  typedef struct packed {
    logic [1:0] key_i;
    logic [1:0] key_j;
    logic [1:0] rd_a;
    logic [1:0] rd_b;
    logic [1:0] rd_c;
    logic [1:0] rd_d;
    logic [1:0] wr_m;
    logic [1:0] wr_n;
  } mix_round_t;

  localparam mix_round_t MixSchedule [bkm_pkg::NumRounds] = '{
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3},
    '{2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd0, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd1}
  };

  typedef struct packed {
    logic [bkm_pkg::KeyWidth-1:0]  key;
    logic [bkm_pkg::WordWidth-1:0] data;
  } key_word_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // fields from bit 0 up: mix_key[31:0], data_word[63:0]
  logic [bkm_pkg::InTdataW-1:0]    s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // fields from bit 0 up: mixed_word[63:0]
  logic [bkm_pkg::WordWidth-1:0]   m_axis_tdata;

  key_word_t                       key_word_q [$];
  logic [bkm_pkg::WordWidth-1:0]   mixed_word_q [$];
  int unsigned                     n_planned;
  int unsigned                     n_sent;
  int unsigned                     n_recv;
  int unsigned                     n_err;
  int unsigned                     feed_gap;
  int unsigned                     drain_stall;
  logic                            feed_busy;
  logic                            drain_ready;
  key_word_t                       feed_beat;
  logic [bkm_pkg::WordWidth-1:0]   want_word;

  byte_add_xor_key_mix i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Eight add/XOR rounds over one 4-byte half; all reads of a round precede its writes
  function automatic logic [bkm_pkg::HalfWidth-1:0] mix_half_word(
    input logic [bkm_pkg::KeyWidth-1:0]  key,
    input logic [bkm_pkg::HalfWidth-1:0] half
  );
    bkm_pkg::byte_t                y [bkm_pkg::HalfBytes];
    bkm_pkg::byte_t                ki, kj, m, n;
    logic [bkm_pkg::HalfWidth-1:0] res;
    for (int i = 0; i < bkm_pkg::HalfBytes; i++) y[i] = half[8*i +: 8];
    for (int r = 0; r < bkm_pkg::NumRounds; r++) begin
      ki = key[8*MixSchedule[r].key_i +: 8];
      kj = key[8*MixSchedule[r].key_j +: 8];
      m  = (y[MixSchedule[r].rd_a] + (ki ^ kj)) ^ y[MixSchedule[r].rd_b];
      n  = ((ki + kj) + y[MixSchedule[r].rd_c]) ^ y[MixSchedule[r].rd_d];
      y[MixSchedule[r].wr_m] = m;
      y[MixSchedule[r].wr_n] = n;
    end
    for (int i = 0; i < bkm_pkg::HalfBytes; i++) res[8*i +: 8] = y[i];
    return res;
  endfunction

  function automatic logic [bkm_pkg::WordWidth-1:0] mixed_word_of(
    input logic [bkm_pkg::InTdataW-1:0] beat
  );
    logic [bkm_pkg::KeyWidth-1:0]  key;
    logic [bkm_pkg::WordWidth-1:0] data;
    key  = beat[bkm_pkg::KeyWidth-1:0];
    data = beat[bkm_pkg::InTdataW-1:bkm_pkg::KeyWidth];
    return {mix_half_word(key, data[63:32]), mix_half_word(key, data[31:0])};
  endfunction

  // Idle length per beat; the phase rotates between none, occasional and heavy idling
  function automatic int unsigned draw_wait(input int unsigned phase);
    case (phase % 3)
      0: return 0;
      1: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, WaitMax) : 0;
      default: return $urandom_range(0, WaitMax);
    endcase
  endfunction

  // Bytes biased towards the wrap points of mod-256 arithmetic
  function automatic logic [31:0] edgy_bytes();
    logic [31:0] v;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0: v[8*i +: 8] = 8'h00;
        1: v[8*i +: 8] = 8'h01;
        2: v[8*i +: 8] = 8'h7f;
        3: v[8*i +: 8] = 8'h80;
        4: v[8*i +: 8] = 8'hff;
        default: v[8*i +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  task automatic queue_beat(input logic [31:0] key, input logic [63:0] data);
    key_word_t b;
    b.key  = key;
    b.data = data;
    key_word_q.push_back(b);
    n_planned++;
  endtask

  // Feed side: a beat stays valid until taken, then the next one follows after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      feed_gap = draw_wait(0);
    end else begin
      feed_busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        mixed_word_q.push_back(mixed_word_of(s_axis_tdata));
        n_sent++;
        feed_busy = 1'b0;
        feed_gap  = draw_wait(n_sent / 40);
      end
      if (!feed_busy) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (key_word_q.size() > 0) begin
          feed_beat = key_word_q.pop_front();
          s_axis_tdata <= {feed_beat.data, feed_beat.key};
          feed_busy = 1'b1;
        end
      end
      s_axis_tvalid <= feed_busy;
    end
  end

  // Result side: check each beat, then hold tready low for a drawn stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      drain_stall = draw_wait(1);
    end else begin
      drain_ready = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (mixed_word_q.size() == 0) begin
          $error("mixed_word: unexpected beat %h with nothing outstanding", m_axis_tdata);
          n_err++;
        end else begin
          want_word = mixed_word_q.pop_front();
          if (m_axis_tdata !== want_word) begin
            $error("mixed_word: expected %h, got %h", want_word, m_axis_tdata);
            n_err++;
          end
        end
        n_recv++;
        drain_stall = draw_wait(n_recv / 57 + 1);
        drain_ready = 1'b0;
      end
      if (!drain_ready) begin
        if (drain_stall > 0) drain_stall--;
        else drain_ready = 1'b1;
      end
      m_axis_tready <= drain_ready;
    end
  end

  initial begin
    n_planned = 0;
    n_sent    = 0;
    n_recv    = 0;
    n_err     = 0;

    // directed: all-zero and all-one fields, sign-bit and wrap patterns, lone key bytes
    queue_beat(32'h0000_0000, 64'h0000_0000_0000_0000);
    queue_beat(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    queue_beat(32'h0000_0000, 64'hffff_ffff_ffff_ffff);
    queue_beat(32'hffff_ffff, 64'h0000_0000_0000_0000);
    queue_beat(32'h8080_8080, 64'h8080_8080_8080_8080);
    queue_beat(32'h7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f);
    queue_beat(32'h0101_0101, 64'hffff_ffff_0000_0000);
    queue_beat(32'h0000_00ff, 64'h0123_4567_89ab_cdef);
    queue_beat(32'h0000_ff00, 64'h0123_4567_89ab_cdef);
    queue_beat(32'h00ff_0000, 64'h0123_4567_89ab_cdef);
    queue_beat(32'hff00_0000, 64'h0123_4567_89ab_cdef);
    queue_beat(32'haaaa_aaaa, 64'h5555_5555_5555_5555);
    queue_beat(32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    queue_beat(32'h01ff_01ff, 64'h00ff_00ff_ff00_ff00);
    queue_beat(32'hdead_beef, 64'hdead_beef_dead_beef);
    queue_beat(32'h8000_0001, 64'h8000_0000_0000_0001);

    // random: mostly uniform, a quarter built from wrap-point bytes
    for (int i = 0; i < RandBeats; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_beat(edgy_bytes(), {edgy_bytes(), edgy_bytes()});
      else
        queue_beat($urandom, {$urandom, $urandom});
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent != n_planned) @(posedge clk_i);
    while (mixed_word_q.size() != 0) @(posedge clk_i);
    // keep the clock running so that any stray extra beat is still caught
    repeat (8) @(posedge clk_i);

    $display("Sent %0d key/data beats (directed wrap patterns and random),", n_sent);
    $display("checked %0d mixed words", n_recv);
    $display("Feed gaps and result stalls of 0..%0d cycles, %0d mismatches", WaitMax, n_err);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", mixed_word_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
